/* hw/rtl/vdlw_pkg.sv */
package vdlw_pkg;

   localparam int LIST_ENTRIES_DEF = 2048;

   localparam logic [1:0] ACT_WRITE = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_PULL  = 2'd2;

   localparam logic [1:0] PLANE_CTRL = 2'd0;
   localparam logic [1:0] PLANE_X    = 2'd1;
   localparam logic [1:0] PLANE_Y    = 2'd2;

   localparam logic CSR_CENTER_X = 1'b0;
   localparam logic CSR_CENTER_Y = 1'b1;

   localparam logic [9:0] CENTER_X_RESET = 10'd512;
   localparam logic [9:0] CENTER_Y_RESET = 10'd384;

   typedef struct packed {
      logic       en;
      logic [1:0] plane;
   } plane_wr_type;

   typedef struct packed {
      logic [15:0] ctrl;
      logic [9:0]  x;
      logic [9:0]  y;
   } plane_rd_type;

   function automatic logic [11:0] sext10(input logic [9:0] v);
      return {{2{v[9]}}, v};
   endfunction

endpackage

/* hw/rtl/vdlw_planes.sv */
module vdlw_planes #(
   parameter int LIST_ENTRIES = vdlw_pkg::LIST_ENTRIES_DEF
) (
   input  logic                          clock,
   input  vdlw_pkg::plane_wr_type        wr,
   input  logic [$clog2(LIST_ENTRIES)-1:0] wr_addr,
   input  logic [15:0]                   wr_data,
   input  logic                          rd_en,
   input  logic [$clog2(LIST_ENTRIES)-1:0] rd_addr,
   output vdlw_pkg::plane_rd_type        rd_data
);
   import vdlw_pkg::*;

   logic [15:0] ctrl_mem [LIST_ENTRIES];
   logic [9:0]  x_mem    [LIST_ENTRIES];
   logic [9:0]  y_mem    [LIST_ENTRIES];

   plane_rd_type rd_ff;

   always_ff @(posedge clock) begin
      if (wr.en && wr.plane == PLANE_CTRL) begin
         ctrl_mem[wr_addr] <= wr_data;
      end
      if (wr.en && wr.plane == PLANE_X) begin
         x_mem[wr_addr] <= wr_data[9:0];
      end
      if (wr.en && wr.plane == PLANE_Y) begin
         y_mem[wr_addr] <= wr_data[9:0];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_ff.ctrl <= ctrl_mem[rd_addr];
         rd_ff.x    <= x_mem[rd_addr];
         rd_ff.y    <= y_mem[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

/* hw/rtl/vector_display_list_walker_unit.sv */
// A pull reads the planes, then goes through OBJ once per object entry read while
// scanning, then HDR for the object's origin or DONE at the list end; a pull inside an
// object goes to PT. One write or start beat per cycle while idle; the planes have a
// single registered read port. A pull stalls all requests until its result is
// registered, after any held result is taken. Synchronous active-high reset clears the
// walker to list done and the centers to 512 and 384; the planes are not cleared.
module vector_display_list_walker_unit #(
   parameter int LIST_ENTRIES = vdlw_pkg::LIST_ENTRIES_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_action,
   input  logic [1:0]         req_plane,
   input  logic [10:0]        req_word_index,
   input  logic [15:0]        req_word_data,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [11:0] rsp_screen_x,
   output logic signed [11:0] rsp_screen_y,
   output logic [5:0]         rsp_color,
   output logic [7:0]         rsp_intensity,
   output logic               rsp_list_done,
   input  logic               csr_wr_en,
   input  logic               csr_index,
   input  logic [9:0]         csr_wr_data
);
   import vdlw_pkg::*;

   localparam int ADDR_W = $clog2(LIST_ENTRIES);
   localparam int OBJ_W  = $clog2(LIST_ENTRIES + 1);
   localparam logic [OBJ_W-1:0] OBJ_END = OBJ_W'(LIST_ENTRIES);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_OBJ  = 3'd1;
   localparam logic [2:0] ST_HDR  = 3'd2;
   localparam logic [2:0] ST_PT   = 3'd3;
   localparam logic [2:0] ST_DONE = 3'd4;

   localparam logic [1:0] PH_DONE   = 2'd0;
   localparam logic [1:0] PH_SCAN   = 2'd1;
   localparam logic [1:0] PH_POINTS = 2'd2;

   function automatic logic [ADDR_W-1:0] wrap_addr(input logic [11:0] v);
      return v[ADDR_W-1:0];
   endfunction

   logic [2:0]       state_ff, state_in;
   logic [1:0]       phase_ff, phase_in;
   logic [OBJ_W-1:0] obj_ff, obj_in;
   logic [10:0]      dp_ff, dp_in;
   logic [9:0]       pl_ff, pl_in;
   logic [9:0]       offx_ff, offx_in;
   logic [9:0]       offy_ff, offy_in;
   logic             shared_ff, shared_in;
   logic [5:0]       shcol_ff, shcol_in;
   logic [7:0]       shint_ff, shint_in;
   logic [9:0]       cx_ff, cx_in;
   logic [9:0]       cy_ff, cy_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [11:0]      sx_ff, sx_in;
   logic [11:0]      sy_ff, sy_in;
   logic [5:0]       col_ff, col_in;
   logic [7:0]       int_ff, int_in;
   logic             done_ff, done_in;

   logic             req_accept;
   logic             out_free;
   logic [10:0]      ptr_next;
   logic [OBJ_W-1:0] obj_next;
   logic [10:0]      cnt;
   logic             cnt_pos;
   logic [11:0]      widx_ext;

   plane_wr_type     wr;
   logic             rd_en;
   logic [ADDR_W-1:0] rd_addr;
   plane_rd_type     rd;

   assign req_stall  = state_ff != ST_IDLE;
   assign req_accept = req_valid & ~req_stall;
   assign out_free   = ~rsp_valid_ff | ~rsp_stall;
   assign ptr_next   = dp_ff + 11'd1;
   assign obj_next   = obj_ff + OBJ_W'(1);
   assign cnt        = {rd.y[9], rd.y} + 11'd1;
   assign cnt_pos    = ~cnt[10] && cnt != 11'd0;
   assign widx_ext   = {1'b0, req_word_index};

   vdlw_planes #(
      .LIST_ENTRIES(LIST_ENTRIES)
   ) u_planes (
      .clock  (clock),
      .wr     (wr),
      .wr_addr(wrap_addr(widx_ext)),
      .wr_data(req_word_data),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd)
   );

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      obj_in       = obj_ff;
      dp_in        = dp_ff;
      pl_in        = pl_ff;
      offx_in      = offx_ff;
      offy_in      = offy_ff;
      shared_in    = shared_ff;
      shcol_in     = shcol_ff;
      shint_in     = shint_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      sx_in        = sx_ff;
      sy_in        = sy_ff;
      col_in       = col_ff;
      int_in       = int_ff;
      done_in      = done_ff;
      wr.en        = 1'b0;
      wr.plane     = req_plane;
      rd_en        = 1'b0;
      rd_addr      = '0;

      if (csr_wr_en && csr_index == CSR_CENTER_X) begin
         cx_in = csr_wr_data;
      end
      if (csr_wr_en && csr_index == CSR_CENTER_Y) begin
         cy_in = csr_wr_data;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               case (req_action)
                  ACT_WRITE: begin
                     wr.en = 1'b1;
                  end
                  ACT_START: begin
                     obj_in    = '0;
                     dp_in     = '0;
                     pl_in     = '0;
                     offx_in   = '0;
                     offy_in   = '0;
                     shared_in = 1'b0;
                     shcol_in  = '0;
                     shint_in  = '0;
                     phase_in  = PH_SCAN;
                  end
                  ACT_PULL: begin
                     if (phase_ff == PH_POINTS && pl_ff != '0) begin
                        dp_in    = ptr_next;
                        rd_en    = 1'b1;
                        rd_addr  = wrap_addr({1'b0, ptr_next});
                        state_in = ST_PT;
                     end else if ((phase_ff == PH_POINTS || phase_ff == PH_SCAN)
                                  && obj_ff < OBJ_END) begin
                        phase_in = PH_SCAN;
                        rd_en    = 1'b1;
                        rd_addr  = obj_ff[ADDR_W-1:0];
                        state_in = ST_OBJ;
                     end else begin
                        phase_in = PH_DONE;
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_OBJ: begin
            obj_in = obj_next;
            if (rd.ctrl[14]) begin
               phase_in = PH_DONE;
               state_in = ST_DONE;
            end else if (rd.ctrl[13]) begin
               if (obj_next < OBJ_END) begin
                  rd_en   = 1'b1;
                  rd_addr = obj_next[ADDR_W-1:0];
               end else begin
                  phase_in = PH_DONE;
                  state_in = ST_DONE;
               end
            end else begin
               offx_in  = rd.x;
               offy_in  = rd.y;
               dp_in    = rd.ctrl[11:1];
               rd_en    = 1'b1;
               rd_addr  = wrap_addr({1'b0, rd.ctrl[11:1]});
               state_in = ST_HDR;
            end
         end
         ST_HDR: begin
            if (out_free) begin
               if (rd.ctrl[15:8] != 8'd0) begin
                  shared_in = 1'b1;
                  shcol_in  = rd.ctrl[5:0];
                  shint_in  = rd.ctrl[15:8];
               end else begin
                  shared_in = 1'b0;
                  shcol_in  = '0;
                  shint_in  = '0;
               end
               pl_in        = cnt_pos ? cnt[9:0] : 10'd0;
               phase_in     = cnt_pos ? PH_POINTS : PH_SCAN;
               rsp_valid_in = 1'b1;
               sx_in        = {2'b00, cx_ff} + sext10(offx_ff);
               sy_in        = {2'b00, cy_ff} - sext10(offy_ff);
               col_in       = '0;
               int_in       = '0;
               done_in      = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         ST_PT: begin
            if (out_free) begin
               pl_in = pl_ff - 10'd1;
               if (pl_ff == 10'd1) begin
                  phase_in = PH_SCAN;
               end
               rsp_valid_in = 1'b1;
               sx_in = {2'b00, cx_ff} + sext10(rd.x) + sext10(offx_ff);
               sy_in = {2'b00, cy_ff} - sext10(rd.y) - sext10(offy_ff);
               if (!shared_ff) begin
                  col_in = rd.ctrl[5:0];
                  int_in = rd.ctrl[15:8];
               end else if (rd.ctrl[15:8] == 8'd0) begin
                  col_in = '0;
                  int_in = '0;
               end else begin
                  col_in = shcol_ff;
                  int_in = shint_ff;
               end
               done_in  = 1'b0;
               state_in = ST_IDLE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               sx_in        = '0;
               sy_in        = '0;
               col_in       = '0;
               int_in       = '0;
               done_in      = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DONE;
         obj_ff       <= '0;
         dp_ff        <= '0;
         pl_ff        <= '0;
         offx_ff      <= '0;
         offy_ff      <= '0;
         shared_ff    <= 1'b0;
         shcol_ff     <= '0;
         shint_ff     <= '0;
         cx_ff        <= CENTER_X_RESET;
         cy_ff        <= CENTER_Y_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         obj_ff       <= obj_in;
         dp_ff        <= dp_in;
         pl_ff        <= pl_in;
         offx_ff      <= offx_in;
         offy_ff      <= offy_in;
         shared_ff    <= shared_in;
         shcol_ff     <= shcol_in;
         shint_ff     <= shint_in;
         cx_ff        <= cx_in;
         cy_ff        <= cy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      sx_ff   <= sx_in;
      sy_ff   <= sy_in;
      col_ff  <= col_in;
      int_ff  <= int_in;
      done_ff <= done_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_screen_x  = sx_ff;
   assign rsp_screen_y  = sy_ff;
   assign rsp_color     = col_ff;
   assign rsp_intensity = int_ff;
   assign rsp_list_done = done_ff;

`ifndef SYNTH
   a_points_left: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_POINTS |-> pl_ff != '0)
      else $error("point phase with no points left");

   a_done_blank: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_list_done |->
         rsp_screen_x == '0 && rsp_screen_y == '0 && rsp_color == '0 && rsp_intensity == '0)
      else $error("list done beat carries a point");

   a_obj_bound: assert property (@(posedge clock) disable iff (reset)
      obj_ff <= OBJ_END)
      else $error("object index past list end");

   a_write_quiet: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_action == ACT_WRITE |=> $stable(phase_ff) && $stable(obj_ff))
      else $error("plane write moved the walker");
`endif

endmodule

/* verif/tb_vector_display_list_walker_unit.sv */
`timescale 1ns / 100ps

module tb_vector_display_list_walker_unit;
   import vdlw_pkg::*;

   localparam int          LIST_DEPTH = LIST_ENTRIES_DEF;
   localparam logic [1:0]  ACT_NONE   = 2'd3;
   localparam logic [1:0]  PLANE_NONE = 2'd3;
   localparam logic [15:0] CTRL_END   = 16'h4000;
   localparam int          IDLE_PCT   = 13;

   typedef enum logic [1:0] {WALK_DONE, WALK_SCAN, WALK_POINTS} walk_state_type;

   typedef struct {
      logic [1:0]  action;
      logic [1:0]  plane;
      logic [10:0] index;
      logic [15:0] data;
   } list_beat_type;

   typedef struct {
      logic signed [11:0] screen_x;
      logic signed [11:0] screen_y;
      logic [5:0]         color;
      logic [7:0]         intensity;
      logic               list_done;
   } beam_point_type;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_action = '0;
   logic [1:0]         req_plane = '0;
   logic [10:0]        req_word_index = '0;
   logic [15:0]        req_word_data = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [11:0] rsp_screen_x;
   logic signed [11:0] rsp_screen_y;
   logic [5:0]         rsp_color;
   logic [7:0]         rsp_intensity;
   logic               rsp_list_done;
   logic               csr_wr_en = 1'b0;
   logic               csr_index = 1'b0;
   logic [9:0]         csr_wr_data = '0;

   list_beat_type  pending_q[$];
   beam_point_type beam_q[$];
   list_beat_type  cur_beat;
   int             err_cnt = 0;
   int             beats_queued = 0;
   bit             calm = 1'b0;

   // predictor state
   logic [15:0]    ctrl_m [LIST_DEPTH];
   logic [9:0]     x_m [LIST_DEPTH];
   logic [9:0]     y_m [LIST_DEPTH];
   int             obj_idx = 0;
   logic [10:0]    def_ptr = '0;
   int             pts_left = 0;
   walk_state_type walk_state = WALK_DONE;
   logic [9:0]     off_x = '0;
   logic [9:0]     off_y = '0;
   logic           shared_style = 1'b0;
   logic [5:0]     shared_color = '0;
   logic [7:0]     shared_int = '0;
   logic [9:0]     ctr_x = CENTER_X_RESET;
   logic [9:0]     ctr_y = CENTER_Y_RESET;

   vector_display_list_walker_unit u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_action     (req_action),
      .req_plane      (req_plane),
      .req_word_index (req_word_index),
      .req_word_data  (req_word_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_screen_x   (rsp_screen_x),
      .rsp_screen_y   (rsp_screen_y),
      .rsp_color      (rsp_color),
      .rsp_intensity  (rsp_intensity),
      .rsp_list_done  (rsp_list_done),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wr_data    (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic int signed10(input logic [9:0] v);
      return v[9] ? int'(v) - 1024 : int'(v);
   endfunction

   function automatic void push_beam(input int dx, input int dy, input logic [5:0] col,
                                     input logic [7:0] inten);
      beam_point_type b;
      int             sx;
      int             sy;
      sx = int'(ctr_x) + dx;
      sy = int'(ctr_y) - dy;
      b.screen_x  = sx[11:0];
      b.screen_y  = sy[11:0];
      b.color     = col;
      b.intensity = inten;
      b.list_done = 1'b0;
      beam_q.push_back(b);
   endfunction

   function automatic void walk_pull();
      logic [15:0]    c;
      logic [15:0]    hc;
      int             o;
      int             cnt;
      int             dx;
      int             dy;
      beam_point_type done_pt;
      if (walk_state == WALK_POINTS && pts_left > 0) begin
         def_ptr = def_ptr + 11'd1;
         c = ctrl_m[def_ptr];
         dx = signed10(x_m[def_ptr]) + signed10(off_x);
         dy = signed10(y_m[def_ptr]) + signed10(off_y);
         if (shared_style) begin
            if (c[15:8] == 8'h00) push_beam(dx, dy, 6'd0, 8'd0);
            else push_beam(dx, dy, shared_color, shared_int);
         end else begin
            push_beam(dx, dy, c[5:0], c[15:8]);
         end
         pts_left--;
         if (pts_left == 0) walk_state = WALK_SCAN;
         return;
      end
      if (walk_state == WALK_POINTS) walk_state = WALK_SCAN;
      while (walk_state == WALK_SCAN && obj_idx < LIST_DEPTH) begin
         o = obj_idx;
         c = ctrl_m[o];
         obj_idx++;
         if (c[14]) begin
            walk_state = WALK_DONE;
            break;
         end
         if (c[13]) continue;
         off_x = x_m[o];
         off_y = y_m[o];
         def_ptr = c[11:1];
         hc = ctrl_m[def_ptr];
         cnt = signed10(y_m[def_ptr]) + 1;
         shared_style = (hc[15:8] != 8'h00);
         shared_color = shared_style ? hc[5:0] : 6'd0;
         shared_int   = shared_style ? hc[15:8] : 8'd0;
         pts_left = (cnt > 0) ? cnt : 0;
         walk_state = (pts_left > 0) ? WALK_POINTS : WALK_SCAN;
         push_beam(signed10(off_x), signed10(off_y), 6'd0, 8'd0);
         return;
      end
      walk_state = WALK_DONE;
      done_pt.screen_x  = '0;
      done_pt.screen_y  = '0;
      done_pt.color     = '0;
      done_pt.intensity = '0;
      done_pt.list_done = 1'b1;
      beam_q.push_back(done_pt);
   endfunction

   function automatic void predict_beat(input list_beat_type b);
      case (b.action)
         ACT_WRITE: begin
            case (b.plane)
               PLANE_CTRL: ctrl_m[b.index] = b.data;
               PLANE_X:    x_m[b.index] = b.data[9:0];
               PLANE_Y:    y_m[b.index] = b.data[9:0];
               default: ;
            endcase
         end
         ACT_START: begin
            obj_idx = 0;
            def_ptr = '0;
            pts_left = 0;
            off_x = '0;
            off_y = '0;
            shared_style = 1'b0;
            shared_color = '0;
            shared_int = '0;
            walk_state = WALK_SCAN;
         end
         ACT_PULL: walk_pull();
         default: ;
      endcase
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         err_cnt++;
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_beat(cur_beat);
         if (!req_valid || !req_stall) begin
            if (pending_q.size() > 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
               cur_beat = pending_q.pop_front();
               req_valid      <= 1'b1;
               req_action     <= cur_beat.action;
               req_plane      <= cur_beat.plane;
               req_word_index <= cur_beat.index;
               req_word_data  <= cur_beat.data;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin : rsp_monitor
      beam_point_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (beam_q.size() == 0) begin
            $error("result beat with no expectation pending");
            err_cnt++;
         end else begin
            want = beam_q.pop_front();
            check_field("screen_x", 32'(want.screen_x), 32'(rsp_screen_x));
            check_field("screen_y", 32'(want.screen_y), 32'(rsp_screen_y));
            check_field("color", 32'(want.color), 32'(rsp_color));
            check_field("intensity", 32'(want.intensity), 32'(rsp_intensity));
            check_field("list_done", 32'(want.list_done), 32'(rsp_list_done));
         end
      end
      rsp_stall <= !calm && ($urandom_range(0, 99) < IDLE_PCT);
   end

   function automatic void put_beat(input logic [1:0] action, input logic [1:0] plane,
                                    input logic [10:0] index, input logic [15:0] data);
      list_beat_type b;
      b.action = action;
      b.plane  = plane;
      b.index  = index;
      b.data   = data;
      pending_q.push_back(b);
      beats_queued++;
   endfunction

   function automatic void put_word(input logic [1:0] plane, input logic [10:0] index,
                                    input logic [15:0] data);
      put_beat(ACT_WRITE, plane, index, data);
   endfunction

   function automatic void put_start();
      put_beat(ACT_START, 2'($urandom), 11'($urandom), 16'($urandom));
   endfunction

   function automatic void put_pull();
      put_beat(ACT_PULL, 2'($urandom), 11'($urandom), 16'($urandom));
   endfunction

   function automatic void put_noise();
      if ($urandom_range(0, 1)) begin
         put_beat(ACT_NONE, 2'($urandom), 11'($urandom), 16'($urandom));
      end else begin
         put_beat(ACT_WRITE, PLANE_NONE, 11'($urandom), 16'($urandom));
      end
   endfunction

   task automatic queue_scene();
      logic [10:0] defs [8];
      logic        skip [8];
      logic [9:0]  hdr_y;
      logic [15:0] c;
      logic [10:0] a;
      int          n_obj;
      int          cnt;
      int          est;
      int          pulls;
      n_obj = $urandom_range(1, 6);
      est = 1;
      for (int k = 0; k < n_obj; k++) begin
         if (k == n_obj - 1 && $urandom_range(0, 7) == 0) begin
            defs[k] = 11'($urandom_range(2040, 2047));
         end else begin
            defs[k] = 11'(64 + k * 320 + $urandom_range(0, 280));
         end
         skip[k] = ($urandom_range(0, 9) == 0);
         case ($urandom_range(0, 9))
            0:       hdr_y = 10'h3ff;
            1:       hdr_y = 10'($urandom_range(10'h200, 10'h3fe));
            2:       hdr_y = 10'($urandom_range(8, 16));
            default: hdr_y = 10'($urandom_range(0, 5));
         endcase
         c = 16'($urandom);
         if ($urandom_range(0, 1)) c[15:8] = 8'h00;
         put_word(PLANE_CTRL, defs[k], c);
         c = 16'($urandom);
         put_word(PLANE_Y, defs[k], {c[15:10], hdr_y});
         cnt = hdr_y[9] ? 0 : int'(hdr_y) + 1;
         for (int p = 1; p <= cnt; p++) begin
            a = defs[k] + 11'(p);
            put_word(PLANE_CTRL, a, 16'($urandom));
            put_word(PLANE_X, a, 16'($urandom));
            put_word(PLANE_Y, a, 16'($urandom));
         end
         if (!skip[k]) est += 1 + cnt;
      end
      for (int k = 0; k < n_obj; k++) begin
         c = 16'($urandom);
         c[14] = 1'b0;
         c[13] = skip[k];
         c[11:1] = defs[k];
         put_word(PLANE_CTRL, 11'(k), c);
         put_word(PLANE_X, 11'(k), 16'($urandom));
         put_word(PLANE_Y, 11'(k), 16'($urandom));
      end
      c = 16'($urandom);
      put_word(PLANE_CTRL, 11'(n_obj), c | CTRL_END);
      put_start();
      pulls = est + $urandom_range(0, 2);
      if ($urandom_range(0, 6) == 0) pulls = $urandom_range(1, est);
      for (int i = 0; i < pulls; i++) begin
         if ($urandom_range(0, 19) == 0) put_noise();
         put_pull();
      end
   endtask

   task automatic drain();
      @(negedge clock);
      while (pending_q.size() != 0 || req_valid || beam_q.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_center(input logic idx, input logic [9:0] val);
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      if (idx == CSR_CENTER_X) ctr_x = val;
      else ctr_y = val;
   endtask

   initial begin
      int scene;
      int base;
      int cfg_step;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      put_pull();

      put_word(PLANE_CTRL, 11'd0, 16'd200);
      put_word(PLANE_X, 11'd0, 16'hfdff);
      put_word(PLANE_Y, 11'd0, 16'h0200);
      put_word(PLANE_CTRL, 11'd100, 16'h0000);
      put_word(PLANE_Y, 11'd100, 16'h0001);
      put_word(PLANE_CTRL, 11'd101, 16'hff3f);
      put_word(PLANE_X, 11'd101, 16'h03ff);
      put_word(PLANE_Y, 11'd101, 16'h0000);
      put_word(PLANE_CTRL, 11'd102, 16'h1234);
      put_word(PLANE_X, 11'd102, 16'h0200);
      put_word(PLANE_Y, 11'd102, 16'h01ff);
      put_word(PLANE_CTRL, 11'd1, 16'ha000);
      put_word(PLANE_X, 11'd1, 16'h0155);
      put_word(PLANE_Y, 11'd1, 16'h02aa);
      put_word(PLANE_CTRL, 11'd2, 16'h0ffe);
      put_word(PLANE_X, 11'd2, 16'h0001);
      put_word(PLANE_Y, 11'd2, 16'h03ff);
      put_word(PLANE_CTRL, 11'h7ff, 16'hc52a);
      put_word(PLANE_Y, 11'h7ff, 16'h0001);
      put_word(PLANE_CTRL, 11'd3, 16'd600);
      put_word(PLANE_X, 11'd3, 16'h0100);
      put_word(PLANE_Y, 11'd3, 16'h0300);
      put_word(PLANE_CTRL, 11'd300, 16'h0000);
      put_word(PLANE_Y, 11'd300, 16'h03fe);
      put_word(PLANE_CTRL, 11'd4, CTRL_END);
      put_noise();
      put_start();
      put_noise();
      repeat (9) put_pull();
      drain();

      scene = 0;
      cfg_step = 0;
      base = beats_queued;
      while (beats_queued - base < 800) begin
         if (scene % 4 == 3) begin
            drain();
            case (cfg_step)
               0: begin
                  write_center(CSR_CENTER_X, 10'd0);
                  write_center(CSR_CENTER_Y, 10'd0);
               end
               1: begin
                  write_center(CSR_CENTER_X, 10'd1023);
                  write_center(CSR_CENTER_Y, 10'd1023);
               end
               2: begin
                  write_center(CSR_CENTER_X, 10'd0);
                  write_center(CSR_CENTER_Y, 10'd1023);
               end
               3: begin
                  write_center(CSR_CENTER_X, 10'd1023);
                  write_center(CSR_CENTER_Y, 10'd0);
               end
               default: begin
                  write_center(CSR_CENTER_X, 10'($urandom));
                  write_center(CSR_CENTER_Y, 10'($urandom));
               end
            endcase
            cfg_step++;
         end
         while (pending_q.size() > 16) @(negedge clock);
         calm = (scene >= 6 && scene < 10);
         queue_scene();
         scene++;
      end
      drain();
      calm = 1'b0;

      if (err_cnt == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

   initial begin
      #(2_000_000);
      $display("TEST FAILED");
      $finish;
   end

endmodule
